/* design/bgauge_pkg.sv */
`default_nettype none

package bgauge_pkg;

   // Field widths
   localparam int PinW  = 12;
   localparam int MvW   = 16;
   localparam int PctW  = 7;
   localparam int LvlW  = 3;
   localparam int DivW  = 5;
   localparam int TrimW = 11;
   localparam int WarmW = 8;
   localparam int HystW = 10;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // Scale chain: pin * divider, then * trim, then / 1000 by reciprocal
   localparam int Prod1W = PinW + DivW;
   localparam int Prod2W = Prod1W + TrimW;
   localparam int DivShift = 38;
   localparam int DivRecipW = 29;
   localparam logic [DivRecipW-1:0] DIV_RECIP = 29'd274877907; // ceil(2^38 / 1000)
   localparam int QuotW = Prod2W + DivRecipW;

   // Open-circuit curve, highest point first
   localparam int CURVE_POINTS = 13;
   localparam int SegW = $clog2(CURVE_POINTS);
   localparam logic [MvW-1:0] CURVE_MV [CURVE_POINTS] = '{
      16'd4200, 16'd4100, 16'd4000, 16'd3930, 16'd3870, 16'd3820, 16'd3790,
      16'd3770, 16'd3740, 16'd3680, 16'd3600, 16'd3500, 16'd3300
   };
   localparam logic [PctW-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
      7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
   };
   // ceil(2^20 / span) of the segment ending at point i; point 0 ends no segment and holds zero
   localparam int RecipShift = 20;
   localparam int RecipW = 17;
   localparam logic [RecipW-1:0] SEG_RECIP [CURVE_POINTS] = '{
      17'd0,     17'd10486, 17'd10486, 17'd14980, 17'd17477, 17'd20972, 17'd34953,
      17'd52429, 17'd34953, 17'd17477, 17'd13108, 17'd10486, 17'd5243
   };
   localparam int NumW = MvW + PctW + 1;
   localparam logic [PctW-1:0] PCT_FULL = 7'd100;
   localparam logic [PctW-1:0] PCT_EMPTY = 7'd0;

   typedef enum logic [LvlW-1:0] {
      LvlUnknown  = 3'd0,
      LvlAbsent   = 3'd1,
      LvlNormal   = 3'd2,
      LvlLow      = 3'd3,
      LvlCritical = 3'd4
   } level_type;

   typedef enum logic [CsrIdxW-1:0] {
      RegDivider  = 3'd0,
      RegTrim     = 3'd1,
      RegWarmup   = 3'd2,
      RegAbsent   = 3'd3,
      RegLow      = 3'd4,
      RegCritical = 3'd5,
      RegHyst     = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [DivW-1:0]  div_ratio;
      logic [TrimW-1:0] trim_permille;
      logic [WarmW-1:0] warmup_periods;
      logic [MvW-1:0]   absent_floor;
      logic [MvW-1:0]   low_mv;
      logic [MvW-1:0]   crit_floor;
      logic [HystW-1:0] hyst_margin;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic trim;
      logic divide;
      logic classify;
      logic percent;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic sample_ok;
   } sts_type;

endpackage

`default_nettype wire

/* design/bgauge_csr.sv */
`default_nettype none

module bgauge_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [bgauge_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [bgauge_pkg::CsrDataW-1:0]  csr_wdata,
   output bgauge_pkg::cfg_type                   cfg
);

   bgauge_pkg::cfg_type cfg_ff;
   bgauge_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (bgauge_pkg::csr_idx_type'(csr_index))
            bgauge_pkg::RegDivider:  cfg_in.div_ratio      = csr_wdata[bgauge_pkg::DivW-1:0];
            bgauge_pkg::RegTrim:     cfg_in.trim_permille  = csr_wdata[bgauge_pkg::TrimW-1:0];
            bgauge_pkg::RegWarmup:   cfg_in.warmup_periods = csr_wdata[bgauge_pkg::WarmW-1:0];
            bgauge_pkg::RegAbsent:   cfg_in.absent_floor   = csr_wdata;
            bgauge_pkg::RegLow:      cfg_in.low_mv         = csr_wdata;
            bgauge_pkg::RegCritical: cfg_in.crit_floor     = csr_wdata;
            bgauge_pkg::RegHyst:     cfg_in.hyst_margin    = csr_wdata[bgauge_pkg::HystW-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.div_ratio      <= 5'd2;
         cfg_ff.trim_permille  <= 11'd1000;
         cfg_ff.warmup_periods <= 8'd13;
         cfg_ff.absent_floor   <= 16'd2000;
         cfg_ff.low_mv         <= 16'd3550;
         cfg_ff.crit_floor     <= 16'd3300;
         cfg_ff.hyst_margin    <= 10'd60;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/bgauge_dp.sv */
`default_nettype none

module bgauge_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bgauge_pkg::cfg_type            cfg,
   input  wire bgauge_pkg::cmd_type            cmd,
   output bgauge_pkg::sts_type                 sts,
   input  wire logic [bgauge_pkg::PinW-1:0]    req_pin_mv,
   input  wire logic                           req_sample_ok,
   output logic [bgauge_pkg::MvW-1:0]          rsp_cell_mv,
   output logic [bgauge_pkg::LvlW-1:0]         rsp_level,
   output logic [bgauge_pkg::PctW-1:0]         rsp_charge_percent,
   output logic                                rsp_warmed_up
);

   // transaction-local registers
   logic [bgauge_pkg::PinW-1:0]   pin_ff;
   logic                          ok_ff;
   logic                          warm_ff;
   logic [bgauge_pkg::Prod1W-1:0] prod1_ff;
   logic [bgauge_pkg::Prod2W-1:0] prod2_ff;
   logic [bgauge_pkg::NumW-1:0]   num_ff;
   logic [bgauge_pkg::RecipW-1:0] recip_ff;
   logic [bgauge_pkg::PctW-1:0]   base_ff;
   logic                          top_ff;
   logic                          bottom_ff;

   // gauge state
   logic [bgauge_pkg::WarmW-1:0]  period_ff;
   logic [bgauge_pkg::MvW-1:0]    cell_ff;
   bgauge_pkg::level_type         level_ff;
   logic                          warm_flag_ff;
   logic [bgauge_pkg::PctW-1:0]   charge_ff;

   // result register
   logic [bgauge_pkg::MvW-1:0]    rsp_cell_ff;
   bgauge_pkg::level_type         rsp_level_ff;
   logic [bgauge_pkg::PctW-1:0]   rsp_charge_ff;
   logic                          rsp_warm_ff;

   logic [bgauge_pkg::Prod1W-1:0] prod1_in;
   logic [bgauge_pkg::Prod2W-1:0] prod2_in;
   logic [bgauge_pkg::QuotW-1:0]  quot_full;
   logic [bgauge_pkg::QuotW-bgauge_pkg::DivShift-1:0] quot;
   logic [bgauge_pkg::MvW-1:0]    cell_in;

   logic [bgauge_pkg::MvW:0]      crit_hyst;
   logic [bgauge_pkg::MvW:0]      low_hyst;
   bgauge_pkg::level_type         class_lvl;
   bgauge_pkg::level_type         level_in;

   logic [bgauge_pkg::SegW-1:0]   seg_idx;
   logic [bgauge_pkg::SegW-1:0]   seg_hi;
   logic [bgauge_pkg::MvW-1:0]    span;
   logic [bgauge_pkg::MvW-1:0]    into;
   logic [bgauge_pkg::PctW-1:0]   rise;
   logic [bgauge_pkg::NumW-1:0]   num_in;

   logic [bgauge_pkg::NumW+bgauge_pkg::RecipW-1:0] frac_full;
   logic [bgauge_pkg::PctW-1:0]   frac;
   logic                          present;
   logic [bgauge_pkg::PctW-1:0]   charge_in;

   // scale chain
   assign prod1_in  = bgauge_pkg::Prod1W'(pin_ff) * bgauge_pkg::Prod1W'(cfg.div_ratio);
   assign prod2_in  = bgauge_pkg::Prod2W'(prod1_ff) * bgauge_pkg::Prod2W'(cfg.trim_permille);
   assign quot_full = bgauge_pkg::QuotW'(prod2_ff) * bgauge_pkg::QuotW'(bgauge_pkg::DIV_RECIP);
   assign quot      = quot_full[bgauge_pkg::QuotW-1:bgauge_pkg::DivShift];
   assign cell_in   = (quot > {{(bgauge_pkg::QuotW-bgauge_pkg::DivShift-bgauge_pkg::MvW){1'b0}},
                                {bgauge_pkg::MvW{1'b1}}}) ?
                      {bgauge_pkg::MvW{1'b1}} : quot[bgauge_pkg::MvW-1:0];

   // classification with upward hysteresis
   assign crit_hyst = {1'b0, cfg.crit_floor} + (bgauge_pkg::MvW+1)'(cfg.hyst_margin);
   assign low_hyst  = {1'b0, cfg.low_mv} + (bgauge_pkg::MvW+1)'(cfg.hyst_margin);

   always_comb begin
      priority if (cell_ff < cfg.absent_floor) begin
         class_lvl = bgauge_pkg::LvlAbsent;
      end else if (cell_ff < cfg.crit_floor) begin
         class_lvl = bgauge_pkg::LvlCritical;
      end else if (level_ff == bgauge_pkg::LvlCritical && {1'b0, cell_ff} < crit_hyst) begin
         class_lvl = bgauge_pkg::LvlCritical;
      end else if (cell_ff < cfg.low_mv) begin
         class_lvl = bgauge_pkg::LvlLow;
      end else if ((level_ff == bgauge_pkg::LvlLow || level_ff == bgauge_pkg::LvlCritical) &&
                   {1'b0, cell_ff} < low_hyst) begin
         class_lvl = bgauge_pkg::LvlLow;
      end else begin
         class_lvl = bgauge_pkg::LvlNormal;
      end
   end

   assign level_in = warm_ff ? class_lvl : bgauge_pkg::LvlUnknown;

   // first curve segment whose lower point lies below the cell voltage
   always_comb begin
      seg_idx = bgauge_pkg::SegW'(1);
      for (int i = bgauge_pkg::CURVE_POINTS - 1; i >= 1; i--) begin
         if (cell_ff > bgauge_pkg::CURVE_MV[i]) begin
            seg_idx = bgauge_pkg::SegW'(i);
         end
      end
   end

   assign seg_hi = seg_idx - bgauge_pkg::SegW'(1);
   assign span   = bgauge_pkg::CURVE_MV[seg_hi] - bgauge_pkg::CURVE_MV[seg_idx];
   assign into   = cell_ff - bgauge_pkg::CURVE_MV[seg_idx];
   assign rise   = bgauge_pkg::CURVE_PCT[seg_hi] - bgauge_pkg::CURVE_PCT[seg_idx];
   assign num_in = bgauge_pkg::NumW'(into) * bgauge_pkg::NumW'(rise)
                 + bgauge_pkg::NumW'(span >> 1);

   // rounded interpolation: numerator / span by reciprocal
   assign frac_full = (bgauge_pkg::NumW+bgauge_pkg::RecipW)'(num_ff)
                    * (bgauge_pkg::NumW+bgauge_pkg::RecipW)'(recip_ff);
   assign frac      = frac_full[bgauge_pkg::RecipShift +: bgauge_pkg::PctW];
   assign present   = level_ff != bgauge_pkg::LvlUnknown && level_ff != bgauge_pkg::LvlAbsent;

   always_comb begin
      priority if (!present) begin
         charge_in = bgauge_pkg::PCT_EMPTY;
      end else if (top_ff) begin
         charge_in = bgauge_pkg::PCT_FULL;
      end else if (bottom_ff) begin
         charge_in = bgauge_pkg::PCT_EMPTY;
      end else begin
         charge_in = base_ff + frac;
      end
   end

   // transaction datapath
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pin_ff  <= req_pin_mv;
         ok_ff   <= req_sample_ok;
         warm_ff <= period_ff >= cfg.warmup_periods;
      end
      if (cmd.scale) begin
         prod1_ff <= prod1_in;
      end
      if (cmd.trim) begin
         prod2_ff <= prod2_in;
      end
      if (cmd.classify) begin
         num_ff    <= num_in;
         recip_ff  <= bgauge_pkg::SEG_RECIP[seg_idx];
         base_ff   <= bgauge_pkg::CURVE_PCT[seg_idx];
         top_ff    <= cell_ff >= bgauge_pkg::CURVE_MV[0];
         bottom_ff <= cell_ff <= bgauge_pkg::CURVE_MV[bgauge_pkg::CURVE_POINTS-1];
      end
      if (cmd.publish) begin
         rsp_cell_ff   <= cell_ff;
         rsp_level_ff  <= level_ff;
         rsp_charge_ff <= charge_ff;
         rsp_warm_ff   <= warm_flag_ff;
      end
   end

   // gauge state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= '0;
         cell_ff      <= '0;
         level_ff     <= bgauge_pkg::LvlUnknown;
         warm_flag_ff <= 1'b0;
         charge_ff    <= '0;
      end else begin
         if (cmd.load && period_ff != {bgauge_pkg::WarmW{1'b1}}) begin
            period_ff <= period_ff + bgauge_pkg::WarmW'(1);
         end
         if (cmd.divide) begin
            cell_ff <= cell_in;
         end
         if (cmd.classify) begin
            level_ff     <= level_in;
            warm_flag_ff <= warm_ff;
         end
         if (cmd.percent) begin
            charge_ff <= charge_in;
         end
      end
   end

   assign sts.sample_ok      = ok_ff;
   assign rsp_cell_mv        = rsp_cell_ff;
   assign rsp_level          = rsp_level_ff;
   assign rsp_charge_percent = rsp_charge_ff;
   assign rsp_warmed_up      = rsp_warm_ff;

   a_level_needs_warm: assert property (@(posedge clock) disable iff (reset)
      level_ff != bgauge_pkg::LvlUnknown |-> warm_flag_ff)
      else $error("level classified while not warmed up");

   // the charge trails the level by the percent step
   a_charge_needs_cell: assert property (@(posedge clock) disable iff (reset)
      charge_ff != '0 && !cmd.percent |-> (level_ff != bgauge_pkg::LvlUnknown &&
                                           level_ff != bgauge_pkg::LvlAbsent))
      else $error("charge reported without a present cell");

   a_charge_range: assert property (@(posedge clock) disable iff (reset)
      cmd.percent |=> charge_ff <= bgauge_pkg::PCT_FULL)
      else $error("charge above full scale");

endmodule

`default_nettype wire

/* design/bgauge_ctrl.sv */
`default_nettype none

module bgauge_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire bgauge_pkg::sts_type  sts,
   output bgauge_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      StIdle,
      StScale,
      StTrim,
      StDivide,
      StClass,
      StPercent,
      StPublish
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StScale;
            end
         end
         StScale: begin
            cmd.scale = 1'b1;
            // a failed sample skips straight to the held values
            state_in  = sts.sample_ok ? StTrim : StPublish;
         end
         StTrim: begin
            cmd.trim = 1'b1;
            state_in = StDivide;
         end
         StDivide: begin
            cmd.divide = 1'b1;
            state_in   = StClass;
         end
         StClass: begin
            cmd.classify = 1'b1;
            state_in     = StPercent;
         end
         StPercent: begin
            cmd.percent = 1'b1;
            state_in    = StPublish;
         end
         StPublish: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != StIdle;
   assign rsp_valid = rsp_valid_ff;

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == StScale)
      else $error("accepted transaction did not start scaling");

   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff && state_ff == StIdle)
      else $error("published result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !cmd.publish)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

/* design/battery_level_gauge.sv */
// Battery level gauge.
// Input channel (req_*): one averaged pin voltage in mV plus a sample_ok flag per
// transaction, taken when req_valid is high and req_stall low. Result channel
// (rsp_*): one transaction per input with cell voltage, level code, charge percent
// and the warmed-up flag, taken when rsp_valid is high and rsp_stall low.
// CSR port: csr_wr_en writes csr_wdata into register csr_index; write only while no
// transaction is in flight.
// Sequence: the controller steps a good sample through the scale chain (pin x
// divider, x trim, /1000 by reciprocal multiply), the classification step and the
// interpolation divide one per cycle, then holds in the publish step until the
// result register is free; a failed sample goes from the scale step straight to
// publish. The next transaction is taken in the idle state after publishing.
// The result register decouples the sides: while a result waits under rsp_stall the
// next transaction is accepted and computed, and it holds in the publish step until
// the pending result is taken.
// Reset (synchronous) restores default thresholds, clears the warm-up count, sets
// the level to unknown and drops any pending result.
`default_nettype none

module battery_level_gauge (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [bgauge_pkg::PinW-1:0]      req_pin_mv,
   input  wire logic                             req_sample_ok,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [bgauge_pkg::MvW-1:0]            rsp_cell_mv,
   output logic [bgauge_pkg::LvlW-1:0]           rsp_level,
   output logic [bgauge_pkg::PctW-1:0]           rsp_charge_percent,
   output logic                                  rsp_warmed_up,
   input  wire logic                             csr_wr_en,
   input  wire logic [bgauge_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [bgauge_pkg::CsrDataW-1:0]  csr_wdata
);

   bgauge_pkg::cfg_type cfg;
   bgauge_pkg::cmd_type cmd;
   bgauge_pkg::sts_type sts;

   // configuration registers
   bgauge_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: one step of the datapath per cycle unless publish is held, owns both handshakes
   bgauge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // scale, classify, interpolate and hold the gauge state
   bgauge_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .sts                (sts),
      .req_pin_mv         (req_pin_mv),
      .req_sample_ok      (req_sample_ok),
      .rsp_cell_mv        (rsp_cell_mv),
      .rsp_level          (rsp_level),
      .rsp_charge_percent (rsp_charge_percent),
      .rsp_warmed_up      (rsp_warmed_up)
   );

endmodule

`default_nettype wire

/* tb/battery_level_gauge_test.sv */
import bgauge_pkg::*;

class gauge_checker;
   typedef struct {
      logic [MvW-1:0]  cell_mv;
      level_type       level;
      logic [PctW-1:0] percent;
      logic            warm;
   } gauge_reading_type;

   // open-circuit curve, highest point first
   int unsigned knot_mv[13] = '{4200, 4100, 4000, 3930, 3870, 3820, 3790,
                                3770, 3740, 3680, 3600, 3500, 3300};
   int unsigned knot_pct[13] = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 15, 10, 5, 0};

   cfg_type           cfg;
   level_type         lvl;
   int unsigned       periods;
   logic [MvW-1:0]    held_mv;
   logic              warm_flag;
   gauge_reading_type readings_due[$];
   int                errors;

   function new();
      cfg = '{2, 1000, 13, 2000, 3550, 3300, 60};
      lvl = LvlUnknown;
      periods = 0;
      held_mv = '0;
      warm_flag = 1'b0;
      errors = 0;
   endfunction

   function void write_reg(csr_idx_type idx, logic [CsrDataW-1:0] v);
      case (idx)
         RegDivider:  cfg.div_ratio = v[DivW-1:0];
         RegTrim:     cfg.trim_permille = v[TrimW-1:0];
         RegWarmup:   cfg.warmup_periods = v[WarmW-1:0];
         RegAbsent:   cfg.absent_floor = v;
         RegLow:      cfg.low_mv = v;
         RegCritical: cfg.crit_floor = v;
         RegHyst:     cfg.hyst_margin = v[HystW-1:0];
         default: ;
      endcase
   endfunction

   function level_type classify(int unsigned mv);
      int unsigned crit_top;
      int unsigned low_top;
      crit_top = int'(cfg.crit_floor) + int'(cfg.hyst_margin);
      low_top = int'(cfg.low_mv) + int'(cfg.hyst_margin);
      if (mv < int'(cfg.absent_floor)) return LvlAbsent;
      if (mv < int'(cfg.crit_floor)) return LvlCritical;
      if (lvl == LvlCritical && mv < crit_top) return LvlCritical;
      if (mv < int'(cfg.low_mv)) return LvlLow;
      if ((lvl == LvlLow || lvl == LvlCritical) && mv < low_top) return LvlLow;
      return LvlNormal;
   endfunction

   function logic [PctW-1:0] charge_for();
      int unsigned mv;
      int unsigned span;
      int unsigned into;
      int unsigned rise;
      mv = int'(held_mv);
      if (lvl == LvlUnknown || lvl == LvlAbsent) return '0;
      if (mv >= knot_mv[0]) return PctW'(knot_pct[0]);
      if (mv <= knot_mv[12]) return PctW'(knot_pct[12]);
      for (int i = 1; i < 13; i++) begin
         if (mv > knot_mv[i]) begin
            span = knot_mv[i-1] - knot_mv[i];
            into = mv - knot_mv[i];
            rise = knot_pct[i-1] - knot_pct[i];
            return PctW'(knot_pct[i] + (into * rise + span / 2) / span);
         end
      end
      return '0;
   endfunction

   // Work out the reading that one accepted sample produces.
   function void note_sample(logic [PinW-1:0] pin, logic ok);
      gauge_reading_type r;
      int unsigned       scaled;
      bit                warm_now;
      warm_now = (periods >= int'(cfg.warmup_periods));
      if (periods < 255) periods++;
      if (ok) begin
         scaled = int'(pin) * int'(cfg.div_ratio) * int'(cfg.trim_permille) / 1000;
         if (scaled > 65535) scaled = 65535;
         held_mv = MvW'(scaled);
         warm_flag = warm_now;
         lvl = warm_now ? classify(scaled) : LvlUnknown;
      end
      r.cell_mv = held_mv;
      r.level = lvl;
      r.percent = charge_for();
      r.warm = warm_flag;
      readings_due.push_back(r);
   endfunction

   function void check_reading(logic [MvW-1:0] mv, logic [LvlW-1:0] level,
                               logic [PctW-1:0] pct, logic warm);
      gauge_reading_type want;
      if (readings_due.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected reading: cell %0d level %0d pct %0d warm %0b",
                     mv, level, pct, warm);
         return;
      end
      want = readings_due.pop_front();
      if (mv !== want.cell_mv || level !== want.level || pct !== want.percent ||
          warm !== want.warm) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected cell %0d level %0d pct %0d warm %0b,",
                     want.cell_mv, want.level, want.percent, want.warm,
                     " got cell %0d level %0d pct %0d warm %0b", mv, level, pct, warm);
      end
   endfunction
endclass

module battery_level_gauge_test;
   // Directed samples at reset settings: the first thirteen fall inside warm-up,
   // then walk down and up through the classes to exercise the hysteresis.
   localparam logic [PinW-1:0] PROBE_PIN[25] = '{
      0, 4095, 4095, 1, 2100, 1650, 2000, 1234, 0, 4095, 1800, 1900, 1775,
      2100, 1770, 1790, 1810, 1640, 1670, 1690, 1640, 1700, 999, 1650, 4095
   };
   localparam logic PROBE_OK[25] = '{
      1, 1, 0, 1, 1, 0, 1, 1, 0, 1, 1, 1, 1,
      1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1
   };
   localparam int Phases = 8;
   localparam int PhaseItems = 50;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [PinW-1:0]     req_pin_mv;
   logic                req_sample_ok;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [MvW-1:0]      rsp_cell_mv;
   logic [LvlW-1:0]     rsp_level;
   logic [PctW-1:0]     rsp_charge_percent;
   logic                rsp_warmed_up;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   gauge_checker    board;
   int              send_idle_pct = 22;
   int              recv_idle_pct = 76;
   int              sent;
   int              phase;
   logic [PinW-1:0] last_pin;

   battery_level_gauge dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pin_mv         (req_pin_mv),
      .req_sample_ok      (req_sample_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_mv        (rsp_cell_mv),
      .rsp_level          (rsp_level),
      .rsp_charge_percent (rsp_charge_percent),
      .rsp_warmed_up      (rsp_warmed_up),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #400000;
      $display("battery_level_gauge_test NOT OK");
      $finish;
   end

   // Stall the result channel at random; one update per falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Check every result transaction at the edge where it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_reading(rsp_cell_mv, rsp_level, rsp_charge_percent, rsp_warmed_up);
   end

   // Offer one sample, idling first at random, and hold it until accepted.
   task automatic send_sample(input logic [PinW-1:0] pin, input logic ok);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pin_mv <= pin;
      req_sample_ok <= ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(pin, ok);
   endtask

   // Drop valid, wait until every reading has come back, then let the pipe drain.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.readings_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Write all seven registers back to back; the block is idle here.
   task automatic apply_config(input cfg_type c);
      csr_idx_type         regs[7] = '{RegDivider, RegTrim, RegWarmup, RegAbsent,
                                       RegLow, RegCritical, RegHyst};
      logic [CsrDataW-1:0] vals[7];
      vals = '{CsrDataW'(c.div_ratio), CsrDataW'(c.trim_permille),
               CsrDataW'(c.warmup_periods), c.absent_floor, c.low_mv, c.crit_floor,
               CsrDataW'(c.hyst_margin)};
      @(negedge clock);
      foreach (regs[i]) begin
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         board.write_reg(regs[i], vals[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Settings per phase, fields in register order: divider, trim, warm-up,
   // absent, low, critical, hysteresis.
   function automatic cfg_type phase_setting(int p);
      cfg_type c;
      case (p)
         0: c = '{2, 1000, 13, 2000, 3550, 3300, 60};
         // top of every range: saturated voltage, hysteresis past 16 bits
         1: c = '{31, 2047, 0, 0, 65535, 65535, 1023};
         // zero divider and trim, all thresholds at zero
         2: c = '{0, 0, 0, 0, 0, 0, 0};
         // critical above low: the fixed test order decides
         3: c = '{2, 1000, 40, 2500, 3400, 3600, 1023};
         // longest warm-up: crosses the saturated sample count mid-phase
         4: c = '{1, 1250, 255, 1000, 3550, 3300, 60};
         default: begin
            c.div_ratio = DivW'($urandom_range(1, 16));
            c.trim_permille = TrimW'($urandom_range(800, 1250));
            c.warmup_periods = WarmW'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) begin
               c.absent_floor = MvW'($urandom_range(1500, 2500));
               c.crit_floor = MvW'($urandom_range(3000, 3600));
               c.low_mv = MvW'(int'(c.crit_floor) + int'($urandom_range(0, 500)));
               c.hyst_margin = HystW'($urandom_range(0, 200));
            end else begin
               c.absent_floor = MvW'($urandom_range(0, 65535));
               c.crit_floor = MvW'($urandom_range(0, 65535));
               c.low_mv = MvW'($urandom_range(0, 65535));
               c.hyst_margin = HystW'($urandom_range(0, 1023));
            end
         end
      endcase
      return c;
   endfunction

   // Mostly walk the pin slowly or land it near a threshold so the level moves
   // through its classes; the rest is fully random.
   function automatic logic [PinW-1:0] pick_pin();
      int unsigned gain;
      int unsigned target;
      int          step;
      int          mode;
      logic [PinW-1:0] pin;
      gain = int'(board.cfg.div_ratio) * int'(board.cfg.trim_permille);
      mode = $urandom_range(0, 99);
      if (gain == 0 || mode < 15) begin
         pin = PinW'($urandom_range(0, 4095));
      end else if (mode < 55) begin
         step = int'(last_pin) + int'($urandom_range(0, 60)) - 30;
         if (step < 0) step = 0;
         if (step > 4095) step = 4095;
         pin = PinW'(step);
      end else begin
         case ($urandom_range(0, 5))
            0: target = int'(board.cfg.absent_floor);
            1: target = int'(board.cfg.crit_floor);
            2: target = int'(board.cfg.low_mv);
            3: target = int'(board.cfg.crit_floor) + int'(board.cfg.hyst_margin);
            4: target = int'(board.cfg.low_mv) + int'(board.cfg.hyst_margin);
            default: target = $urandom_range(3300, 4200);
         endcase
         step = int'(target) + int'($urandom_range(0, 80)) - 40;
         if (step < 0) step = 0;
         target = int'(step) * 1000 / gain + $urandom_range(0, 1);
         if (target > 4095) target = 4095;
         pin = PinW'(target);
      end
      last_pin = pin;
      return pin;
   endfunction

   // Idling schedule: sender light and receiver heavy, then swapped, then none.
   function automatic void pick_idle(int done);
      if (done < Phases * PhaseItems / 3) begin
         send_idle_pct = 22;
         recv_idle_pct = 76;
      end else if (done < 2 * Phases * PhaseItems / 3) begin
         send_idle_pct = 76;
         recv_idle_pct = 22;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endfunction

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_pin_mv = '0;
      req_sample_ok = 1'b0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = RegDivider;
      csr_wdata = '0;
      last_pin = '0;
      sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed samples at reset settings
      foreach (PROBE_PIN[i]) send_sample(PROBE_PIN[i], PROBE_OK[i]);

      // random samples, one register setting per phase
      for (phase = 0; phase < Phases; phase++) begin
         settle();
         apply_config(phase_setting(phase));
         repeat (PhaseItems) begin
            pick_idle(sent);
            send_sample(pick_pin(), $urandom_range(0, 99) < 85);
            sent++;
         end
      end
      settle();

      if (board.errors == 0 && board.readings_due.size() == 0)
         $display("battery_level_gauge_test OK");
      else
         $display("battery_level_gauge_test NOT OK");
      $finish;
   end
endmodule

/* filelist.f */
design/bgauge_pkg.sv
design/bgauge_csr.sv
design/bgauge_dp.sv
design/bgauge_ctrl.sv
design/battery_level_gauge.sv
tb/battery_level_gauge_test.sv
